>>> sv/rrfs_pkg.sv
// shared types and constants of the rolling rank forecast scaler
package rrfs_pkg;

    // field widths
    localparam int SYM_W   = 4;
    localparam int VOL_W   = 24;
    localparam int FC_W    = 24;
    localparam int MULT_W  = 18;
    localparam int ALPHA_W = 17;
    localparam int SCAL_W  = 24;
    localparam int LIM_W   = 23;
    localparam int WLEN_W  = 7;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EWMA_ALPHA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TREND_SCALAR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRY_SCALAR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORECAST_LIMIT = 3'd4;

    // register reset values
    localparam logic [WLEN_W-1:0]  RST_WINDOW_LENGTH  = 7'd64;
    localparam logic [ALPHA_W-1:0] RST_EWMA_ALPHA     = 17'd3972;
    localparam logic [SCAL_W-1:0]  RST_TREND_SCALAR   = 24'd65536;
    localparam logic [SCAL_W-1:0]  RST_CARRY_SCALAR   = 24'd65536;
    localparam logic [LIM_W-1:0]   RST_FORECAST_LIMIT = 23'd1310720;

    // item codes
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_SCALE  = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_NO_HIST = 1'b1;

    // fixed point constants
    localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 17'd65536;
    localparam logic [MULT_W-1:0]  MULT_TWO       = 18'd131072;
    localparam logic [MULT_W-1:0]  ONE_ENTRY_MULT = 18'd65537;
    localparam logic [MULT_W-1:0]  MULT_MIN       = 18'd32768;
    localparam logic [16:0]        RANK_ONE       = 17'd65536;

    typedef enum logic [1:0] {
        RES_UPDATE,
        RES_SCALE,
        RES_ERROR
    } t_res_kind;

    // controller to datapath
    typedef struct packed {
        logic      ld_item;
        logic      wr_win;
        logic      scan;
        logic      div_init;
        logic      div_step;
        logic      rank;
        logic      ewma_mul;
        logic      ewma_sum;
        logic      scale_mul;
        logic      scale_mul2;
        logic      res_ld;
        t_res_kind res_kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sym_ok;
        logic is_scale;
        logic hist_valid;
        logic one_entry;
        logic scan_done;
        logic div_done;
    } t_sts;

endpackage

>>> sv/rrfs_ctrl.sv
// sequencing state machine of the rolling rank forecast scaler
module rrfs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rrfs_pkg::t_cmd o_cmd,
    input  rrfs_pkg::t_sts i_sts
);
    import rrfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WRITE,
        S_SCAN,
        S_DIV_INIT,
        S_DIV,
        S_RANK,
        S_EWMA_MUL,
        S_EWMA_SUM,
        S_SCALE_MUL,
        S_SCALE_MUL2,
        S_DONE
    } t_state;

    t_state    r_state;
    logic      r_out_vld;
    t_res_kind r_kind;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    // commands decoded from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.res_kind = r_kind;
        case (r_state)
            S_IDLE:       o_cmd.ld_item    = i_in_valid;
            S_WRITE:      o_cmd.wr_win     = 1'b1;
            S_SCAN:       o_cmd.scan       = 1'b1;
            S_DIV_INIT:   o_cmd.div_init   = 1'b1;
            S_DIV:        o_cmd.div_step   = 1'b1;
            S_RANK:       o_cmd.rank       = 1'b1;
            S_EWMA_MUL:   o_cmd.ewma_mul   = 1'b1;
            S_EWMA_SUM:   o_cmd.ewma_sum   = 1'b1;
            S_SCALE_MUL:  o_cmd.scale_mul  = 1'b1;
            S_SCALE_MUL2: o_cmd.scale_mul2 = 1'b1;
            S_DONE:       o_cmd.res_ld     = !r_out_vld || i_out_ready;
            default:      o_cmd            = '0;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_kind    <= RES_ERROR;
        end else begin
            if (o_cmd.res_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    if (!i_sts.sym_ok) begin
                        r_kind  <= RES_ERROR;
                        r_state <= S_DONE;
                    end else if (!i_sts.is_scale) begin
                        r_kind  <= RES_UPDATE;
                        r_state <= S_WRITE;
                    end else if (!i_sts.hist_valid) begin
                        r_kind  <= RES_ERROR;
                        r_state <= S_DONE;
                    end else begin
                        r_kind  <= RES_SCALE;
                        r_state <= S_SCALE_MUL;
                    end
                end
                S_WRITE: r_state <= S_SCAN;
                S_SCAN: begin
                    if (i_sts.one_entry) r_state <= S_RANK;
                    else if (i_sts.scan_done) r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: r_state <= S_DIV;
                S_DIV: begin
                    if (i_sts.div_done) r_state <= S_RANK;
                end
                S_RANK:       r_state <= S_EWMA_MUL;
                S_EWMA_MUL:   r_state <= S_EWMA_SUM;
                S_EWMA_SUM:   r_state <= S_DONE;
                S_SCALE_MUL:  r_state <= S_SCALE_MUL2;
                S_SCALE_MUL2: r_state <= S_DONE;
                S_DONE: begin
                    if (o_cmd.res_ld) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // an accepted item blocks the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accepting an item");

    // a loaded result shows up on the output
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_ld |=> o_out_valid)
        else $error("result loaded but output not valid");

endmodule

>>> sv/rrfs_dp.sv
// datapath: window memory, rank scan, divider, ewma and scaling
module rrfs_dp #(
    parameter int NUM_SYMBOLS = 16,
    parameter int MAX_WINDOW  = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rrfs_pkg::t_cmd                      i_cmd,
    output rrfs_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_we,
    input  logic [rrfs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rrfs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_action,
    input  logic [rrfs_pkg::SYM_W-1:0]          i_symbol_index,
    input  logic [rrfs_pkg::VOL_W-1:0]          i_volatility,
    input  logic signed [rrfs_pkg::FC_W-1:0]    i_raw_forecast,
    input  logic                                i_forecast_type,
    output logic signed [rrfs_pkg::FC_W-1:0]    o_scaled_forecast,
    output logic [rrfs_pkg::MULT_W-1:0]         o_multiplier,
    output logic                                o_status
);
    import rrfs_pkg::*;

    localparam int SW    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int PW    = $clog2(MAX_WINDOW);
    localparam int FW    = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH = NUM_SYMBOLS * MAX_WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = FW + 16;
    localparam int DCW   = $clog2(QW + 1);

    // configuration registers
    logic [WLEN_W-1:0]  r_win_len;
    logic [ALPHA_W-1:0] r_alpha;
    logic [SCAL_W-1:0]  r_trend;
    logic [SCAL_W-1:0]  r_carry;
    logic [LIM_W-1:0]   r_limit;

    // latched item
    logic              r_action;
    logic [SYM_W-1:0]  r_sym;
    logic [VOL_W-1:0]  r_vol;
    logic [FC_W-1:0]   r_raw;
    logic              r_ftype;

    // per-symbol state
    logic [FW-1:0]     r_fill   [NUM_SYMBOLS];
    logic [PW-1:0]     r_head   [NUM_SYMBOLS];
    logic [MULT_W-1:0] r_smooth [NUM_SYMBOLS];
    logic              r_hvalid [NUM_SYMBOLS];

    // window memory
    logic [VOL_W-1:0]  r_mem [DEPTH];
    logic [VOL_W-1:0]  r_rd_data;
    logic              r_rd_vld;

    // scan, divider and arithmetic registers
    logic [FW-1:0]     r_n;
    logic [PW-1:0]     r_pos;
    logic [FW-1:0]     r_left;
    logic [FW-1:0]     r_below;
    logic [FW-1:0]     r_rem;
    logic [QW-1:0]     r_quo;
    logic [DCW-1:0]    r_div_cnt;
    logic [MULT_W-1:0] r_m;
    logic [34:0]       r_p1;
    logic [25:0]       r_m1;
    logic [33:0]       r_m2;

    logic [SW-1:0]      sym_idx;
    logic               sym_ok;
    logic [FW-1:0]      cur_fill;
    logic [PW-1:0]      cur_head;
    logic [MULT_W-1:0]  cur_smooth;
    logic               cur_hvalid;
    logic [8:0]         len9;
    logic [8:0]         eff9;
    logic [FW-1:0]      eff_len;
    logic [FW-1:0]      fill_nxt;
    logic [PW-1:0]      head_nxt;
    logic [FW-1:0]      n_cnt;
    logic [PW-1:0]      pos_dec;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               issue;
    logic               one_entry;
    logic [FW:0]        div_t;
    logic [FW:0]        div_d;
    logic               div_ge;
    logic [16:0]        q;
    logic [18:0]        q3;
    logic [MULT_W-1:0]  m_rank;
    logic [ALPHA_W-1:0] alpha_eff;
    logic [ALPHA_W-1:0] alpha_inv;
    logic [35:0]        ewma_sum;
    logic [MULT_W-1:0]  s_new;
    logic               neg;
    logic [FC_W-1:0]    mag;
    logic [SCAL_W-1:0]  scalar;
    logic [LIM_W-1:0]   mag_c;
    logic [FC_W-1:0]    sf;

    // symbol lookup
    assign sym_idx    = SW'(r_sym);
    assign sym_ok     = (9'(r_sym) < 9'(NUM_SYMBOLS));
    assign cur_fill   = r_fill[sym_idx];
    assign cur_head   = r_head[sym_idx];
    assign cur_smooth = r_smooth[sym_idx];
    assign cur_hvalid = r_hvalid[sym_idx];

    // effective window length and new window size
    always_comb begin
        len9 = 9'(r_win_len);
        if (len9 == 9'd0) begin
            eff9 = 9'd1;
        end else if (len9 > 9'(MAX_WINDOW)) begin
            eff9 = 9'(MAX_WINDOW);
        end else begin
            eff9 = len9;
        end
        eff_len  = FW'(eff9);
        fill_nxt = (cur_fill < FW'(MAX_WINDOW)) ? cur_fill + FW'(1) : cur_fill;
        head_nxt = (cur_head == PW'(MAX_WINDOW - 1)) ? '0 : cur_head + PW'(1);
        n_cnt    = (fill_nxt < eff_len) ? fill_nxt : eff_len;
    end

    // ring addressing
    assign pos_dec   = (r_pos == '0) ? PW'(MAX_WINDOW - 1) : r_pos - PW'(1);
    assign wr_addr   = AW'(int'(sym_idx) * MAX_WINDOW + int'(cur_head));
    assign rd_addr   = AW'(int'(sym_idx) * MAX_WINDOW + int'(r_pos));
    assign issue     = i_cmd.scan && (r_left != '0);
    assign one_entry = (r_n <= FW'(1));

    // restoring divider step
    assign div_t  = {r_rem, r_quo[QW-1]};
    assign div_d  = {1'b0, r_n - FW'(1)};
    assign div_ge = (div_t >= div_d);

    // rank to multiplier
    assign q      = r_quo[16:0];
    assign q3     = {1'b0, q, 1'b0} + 19'(q);
    assign m_rank = one_entry ? ONE_ENTRY_MULT
                              : MULT_TWO - MULT_W'(q3 >> 1);

    // ewma weights
    assign alpha_eff = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign alpha_inv = ALPHA_ONE - alpha_eff;
    assign ewma_sum  = {1'b0, r_p1} + 36'(alpha_inv) * 36'(cur_smooth);
    assign s_new     = cur_hvalid ? MULT_W'(ewma_sum >> 16) : r_m;

    // scaling operands and clamp
    assign neg    = r_raw[FC_W-1];
    assign mag    = neg ? (~r_raw + FC_W'(1)) : r_raw;
    assign scalar = r_ftype ? r_carry : r_trend;
    assign mag_c  = (r_m2 > 34'(r_limit)) ? r_limit : r_m2[LIM_W-1:0];
    assign sf     = neg ? (FC_W'(0) - {1'b0, mag_c}) : {1'b0, mag_c};

    // status to controller
    assign o_sts.sym_ok     = sym_ok;
    assign o_sts.is_scale   = (r_action == ACT_SCALE);
    assign o_sts.hist_valid = cur_hvalid;
    assign o_sts.one_entry  = one_entry;
    assign o_sts.scan_done  = (r_left == '0) && !r_rd_vld;
    assign o_sts.div_done   = (r_div_cnt == '0);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= RST_WINDOW_LENGTH;
            r_alpha   <= RST_EWMA_ALPHA;
            r_trend   <= RST_TREND_SCALAR;
            r_carry   <= RST_CARRY_SCALAR;
            r_limit   <= RST_FORECAST_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH:  r_win_len <= i_cfg_data[WLEN_W-1:0];
                CFG_EWMA_ALPHA:     r_alpha   <= i_cfg_data[ALPHA_W-1:0];
                CFG_TREND_SCALAR:   r_trend   <= i_cfg_data[SCAL_W-1:0];
                CFG_CARRY_SCALAR:   r_carry   <= i_cfg_data[SCAL_W-1:0];
                CFG_FORECAST_LIMIT: r_limit   <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // per-symbol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SYMBOLS; k++) begin
                r_fill[k]   <= '0;
                r_head[k]   <= '0;
                r_smooth[k] <= '0;
                r_hvalid[k] <= 1'b0;
            end
        end else begin
            if (i_cmd.wr_win) begin
                r_fill[sym_idx] <= fill_nxt;
                r_head[sym_idx] <= head_nxt;
            end
            if (i_cmd.ewma_sum) begin
                r_smooth[sym_idx] <= s_new;
                r_hvalid[sym_idx] <= 1'b1;
            end
        end
    end

    // window memory port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_win) begin
            r_mem[wr_addr] <= r_vol;
        end
        if (issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (i_cmd.wr_win) begin
                r_left <= n_cnt;
            end else if (issue) begin
                r_left <= r_left - FW'(1);
            end
        end
    end

    // item latch, counting and arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_action <= i_action;
            r_sym    <= i_symbol_index;
            r_vol    <= i_volatility;
            r_raw    <= i_raw_forecast;
            r_ftype  <= i_forecast_type;
        end
        if (i_cmd.wr_win) begin
            r_n     <= n_cnt;
            r_pos   <= cur_head;
            r_below <= '0;
        end else begin
            if (issue) r_pos <= pos_dec;
            if (r_rd_vld && (r_rd_data < r_vol)) r_below <= r_below + FW'(1);
        end
        if (i_cmd.div_init) begin
            r_rem     <= '0;
            r_quo     <= {r_below, 16'd0};
            r_div_cnt <= DCW'(QW);
        end else if (i_cmd.div_step && (r_div_cnt != '0)) begin
            r_rem     <= div_ge ? FW'(div_t - div_d) : div_t[FW-1:0];
            r_quo     <= {r_quo[QW-2:0], div_ge};
            r_div_cnt <= r_div_cnt - DCW'(1);
        end
        if (i_cmd.rank)       r_m  <= m_rank;
        if (i_cmd.ewma_mul)   r_p1 <= 35'(alpha_eff) * 35'(r_m);
        if (i_cmd.scale_mul)  r_m1 <= 26'((42'(mag) * 42'(cur_smooth)) >> 16);
        if (i_cmd.scale_mul2) r_m2 <= 34'((50'(r_m1) * 50'(scalar)) >> 16);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            case (i_cmd.res_kind)
                RES_UPDATE: begin
                    o_scaled_forecast <= '0;
                    o_multiplier      <= cur_smooth;
                    o_status          <= ST_OK;
                end
                RES_SCALE: begin
                    o_scaled_forecast <= sf;
                    o_multiplier      <= cur_smooth;
                    o_status          <= ST_OK;
                end
                default: begin
                    o_scaled_forecast <= '0;
                    o_multiplier      <= '0;
                    o_status          <= ST_NO_HIST;
                end
            endcase
        end
    end

    // the new sample is never counted below itself
    a_below_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_init |-> (r_below < r_n))
        else $error("rank count not below window size");

    // a rank never exceeds one
    a_rank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rank && !one_entry) |-> (r_quo <= QW'(RANK_ONE)))
        else $error("rank quotient above one");

    // multiplier stays between one half and two
    a_mult_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ewma_mul |-> (r_m >= MULT_MIN && r_m <= MULT_TWO))
        else $error("rank multiplier out of range");

endmodule

>>> sv/rolling_rank_forecast_scaler_unit.sv
// top level of the rolling rank forecast scaler
// Usage: items enter on the input channel (i_in_valid / o_in_ready) and each
// gives one result on the output channel (o_out_valid / i_out_ready).
// Configuration registers are written on a separate channel (i_cfg_valid /
// o_cfg_ready, index and data), always ready; the user is to write them
// only while the block is idle, which the block does not enforce itself.
// A volatility update writes the sample to the window memory, then scans
// the window one entry per cycle through the memory read port, runs a
// one-bit-per-cycle rank divider and the ewma multiply and sum steps; a
// window of one entry skips scan and divider. A scale request runs only
// the scaling multiplies, an error result runs none. One item is in work at
// a time; the next can be taken in the cycle after its predecessor's result
// is loaded. Reset clears configuration to defaults, all symbol fill counts,
// heads and multipliers; the window memory itself is not cleared and needs
// no clearing pass. The result waits in an output register while the
// receiver stalls; the next item may be accepted meanwhile but its result
// is held back until the waiting one is taken.
module rolling_rank_forecast_scaler_unit #(
    parameter int NUM_SYMBOLS = 16,
    parameter int MAX_WINDOW  = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic [rrfs_pkg::SYM_W-1:0]          i_symbol_index,
    input  logic [rrfs_pkg::VOL_W-1:0]          i_volatility,
    input  logic signed [rrfs_pkg::FC_W-1:0]    i_raw_forecast,
    input  logic                                i_forecast_type,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rrfs_pkg::FC_W-1:0]    o_scaled_forecast,
    output logic [rrfs_pkg::MULT_W-1:0]         o_multiplier,
    output logic                                o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rrfs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rrfs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rrfs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // configuration is taken in any cycle
    assign o_cfg_ready = 1'b1;

    rrfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rrfs_dp #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_symbol_index    (i_symbol_index),
        .i_volatility      (i_volatility),
        .i_raw_forecast    (i_raw_forecast),
        .i_forecast_type   (i_forecast_type),
        .o_scaled_forecast (o_scaled_forecast),
        .o_multiplier      (o_multiplier),
        .o_status          (o_status)
    );

endmodule
